@@ src/tlik_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tlik_pkg;

    // Register stages of the square root unit, two result bits per stage
    localparam int SQRT_STAGES  = 16;
    // CORDIC micro-rotations and total latency of one atan2 unit
    localparam int CORDIC_STEPS = 23;
    localparam int ATAN_LAT     = 32;

    // 90 degrees in 1/64 degree
    localparam logic signed [17:0] ANG_RIGHT = 18'sd5760;

    typedef enum logic [2:0] {
        CFG_UPPER_LENGTH     = 3'd0,
        CFG_FORE_LENGTH      = 3'd1,
        CFG_UPPER_ZERO_ANGLE = 3'd2,
        CFG_FORE_ZERO_ANGLE  = 3'd3,
        CFG_UPPER_INVERTED   = 3'd4,
        CFG_FORE_INVERTED    = 3'd5
    } t_cfg_idx;

    // Values that ride along with the square root
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [32:0] n;
        logic signed [33:0] p;
        logic               fail;
    } t_side;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [21:0] atan_step(input logic [4:0] i);
        case (i)
            5'd0:    atan_step = 22'd2949120;
            5'd1:    atan_step = 22'd1740967;
            5'd2:    atan_step = 22'd919879;
            5'd3:    atan_step = 22'd466945;
            5'd4:    atan_step = 22'd234379;
            5'd5:    atan_step = 22'd117304;
            5'd6:    atan_step = 22'd58666;
            5'd7:    atan_step = 22'd29335;
            5'd8:    atan_step = 22'd14668;
            5'd9:    atan_step = 22'd7334;
            5'd10:   atan_step = 22'd3667;
            5'd11:   atan_step = 22'd1833;
            5'd12:   atan_step = 22'd917;
            5'd13:   atan_step = 22'd458;
            5'd14:   atan_step = 22'd229;
            5'd15:   atan_step = 22'd115;
            5'd16:   atan_step = 22'd57;
            5'd17:   atan_step = 22'd29;
            5'd18:   atan_step = 22'd14;
            5'd19:   atan_step = 22'd7;
            5'd20:   atan_step = 22'd4;
            5'd21:   atan_step = 22'd2;
            5'd22:   atan_step = 22'd1;
            default: atan_step = 22'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ src/tlik_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlik_isqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [62:0]    i_rad,
    input  wire tlik_pkg::t_side i_side,
    output logic                o_valid,
    output logic [31:0]         o_root,
    output tlik_pkg::t_side     o_side
);
    import tlik_pkg::*;

    logic        r_v    [1:SQRT_STAGES];
    logic [31:0] r_root [1:SQRT_STAGES];
    t_side       r_side [1:SQRT_STAGES];
    logic [33:0] r_rem  [1:SQRT_STAGES-1];
    logic [63:0] r_rad  [1:SQRT_STAGES-1];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stg
        logic        a_v;
        logic [33:0] a_rem;
        logic [31:0] a_root;
        logic [63:0] a_rad;
        t_side       a_side;
        logic [33:0] n_rem;
        logic [31:0] n_root;

        if (k == 0) begin : g_head
            assign a_v    = i_valid;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = {1'b0, i_rad};
            assign a_side = i_side;
        end else begin : g_body
            assign a_v    = r_v[k];
            assign a_rem  = r_rem[k];
            assign a_root = r_root[k];
            assign a_rad  = r_rad[k];
            assign a_side = r_side[k];
        end

        // two restoring digit steps
        always_comb begin
            logic [35:0] w_rem;
            logic [35:0] w_try;
            n_rem  = a_rem;
            n_root = a_root;
            for (int s = 0; s < 2; s++) begin
                w_rem = {n_rem, a_rad[63-2*s -: 2]};
                w_try = {2'b00, n_root, 2'b01};
                if (w_rem >= w_try) begin
                    n_rem  = 34'(w_rem - w_try);
                    n_root = {n_root[30:0], 1'b1};
                end else begin
                    n_rem  = w_rem[33:0];
                    n_root = {n_root[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= n_root;
                r_side[k+1] <= a_side;
            end
        end

        if (k < SQRT_STAGES - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_rad[k+1] <= {a_rad[59:0], 4'b0000};
                end
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES];
    assign o_root  = r_root[SQRT_STAGES];
    assign o_side  = r_side[SQRT_STAGES];

endmodule

`default_nettype wire

@@ src/tlik_atan2.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlik_atan2 (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [50:0] i_x,
    input  wire logic signed [50:0] i_y,
    output logic signed [16:0]      o_ang
);
    import tlik_pkg::*;

    localparam int W    = 54;
    localparam int NORM = 6;
    localparam logic signed [26:0] ACC_RIGHT = 27'sd5898240;

    logic signed [W-1:0] r_nx  [0:NORM];
    logic signed [W-1:0] r_ny  [0:NORM];
    logic                r_z   [0:NORM+1+CORDIC_STEPS];
    logic signed [W-1:0] r_cx  [0:CORDIC_STEPS];
    logic signed [W-1:0] r_cy  [0:CORDIC_STEPS];
    logic signed [26:0]  r_acc [0:CORDIC_STEPS];
    logic signed [16:0]  r_ang;
    logic signed [26:0]  w_rnd;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= W'(i_x);
            r_ny[0] <= W'(i_y);
            r_z[0]  <= (i_x == '0) && (i_y == '0);
        end
    end

    // scale up until the larger component reaches 2^48
    genvar j;
    for (j = 0; j < NORM; j++) begin : g_norm
        localparam int SH = 32 >> j;
        localparam int TH = 49 - SH;
        logic big;
        assign big = ((mag(r_nx[j]) >> TH) != '0) || ((mag(r_ny[j]) >> TH) != '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j+1] <= big ? r_nx[j] : (r_nx[j] <<< SH);
                r_ny[j+1] <= big ? r_ny[j] : (r_ny[j] <<< SH);
                r_z[j+1]  <= r_z[j];
            end
        end
    end

    // fold the left half plane by a quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[NORM+1] <= r_z[NORM];
            if (r_nx[NORM][W-1]) begin
                if (!r_ny[NORM][W-1]) begin
                    r_cx[0]  <= r_ny[NORM];
                    r_cy[0]  <= -r_nx[NORM];
                    r_acc[0] <= ACC_RIGHT;
                end else begin
                    r_cx[0]  <= -r_ny[NORM];
                    r_cy[0]  <= r_nx[NORM];
                    r_acc[0] <= -ACC_RIGHT;
                end
            end else begin
                r_cx[0]  <= r_nx[NORM];
                r_cy[0]  <= r_ny[NORM];
                r_acc[0] <= '0;
            end
        end
    end

    genvar i;
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic signed [26:0]  da;
        assign xs = r_cx[i] >>> i;
        assign ys = r_cy[i] >>> i;
        assign da = $signed(27'(atan_step(5'(i))));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[NORM+2+i] <= r_z[NORM+1+i];
                if (!r_cy[i][W-1]) begin
                    r_cx[i+1]  <= r_cx[i] + ys;
                    r_cy[i+1]  <= r_cy[i] - xs;
                    r_acc[i+1] <= r_acc[i] + da;
                end else begin
                    r_cx[i+1]  <= r_cx[i] - ys;
                    r_cy[i+1]  <= r_cy[i] + xs;
                    r_acc[i+1] <= r_acc[i] - da;
                end
            end
        end
    end

    assign w_rnd = r_acc[CORDIC_STEPS] + 27'sd512;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_z[NORM+1+CORDIC_STEPS] ? '0 : $signed(w_rnd[26:10]);
        end
    end

    assign o_ang = r_ang;

endmodule

`default_nettype wire

@@ src/two_link_arm_inverse_kinematics_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                    Direction  Transfer when
// target    i_tgt_valid/o_tgt_ready, i_target_x/y      in         valid & ready
// result    o_res_valid/i_res_ready, o_solved, angles  out        valid & ready
// config    i_cfg_we, i_cfg_idx, i_cfg_data            in         write enable
//
// One target per cycle while target ready is high.
// Latency is set mostly by the 16-stage square root and the 32-stage CORDIC atan2 units.
// Reset (synchronous, active low) clears all valid bits and the config registers.
// A stalled result holds in the output register; one more result parks in a
// skid register, then the whole pipeline holds and target ready drops.

module two_link_arm_inverse_kinematics_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tgt_valid,
    output logic                    o_tgt_ready,
    input  wire logic signed [15:0] i_target_x,
    input  wire logic signed [15:0] i_target_y,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic                    o_solved,
    output logic signed [16:0]      o_upper_angle,
    output logic signed [16:0]      o_fore_angle,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    import tlik_pkg::*;

    // configuration
    logic [14:0]        r_upper_len;
    logic [14:0]        r_fore_len;
    logic signed [15:0] r_upper_zero;
    logic signed [15:0] r_fore_zero;
    logic               r_upper_inv;
    logic               r_fore_inv;

    logic               w_en;

    // front stages
    logic               r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic signed [15:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y, r5_x, r5_y;
    logic signed [31:0] r2_xx, r2_yy;
    logic [29:0]        r2_r1sq, r2_r2sq, r3_r1sq;
    logic [31:0]        r3_d2, r4_d2;
    logic signed [30:0] r3_dif;
    logic signed [32:0] r4_n, r5_n;
    logic [63:0]        r4_lim, r5_lim, r5_nsq;
    logic signed [33:0] r5_p;
    logic               r5_d2z;
    logic [31:0]        w_nabs;
    logic [64:0]        w_gap;
    logic [62:0]        r6_rad;
    t_side              r6_side;

    // square root outputs
    logic               s_v;
    logic [31:0]        s_root;
    t_side              s_side;

    // elbow vectors
    logic signed [32:0] w_sm;
    logic               r7_v, r7_fail, r8_v, r8_fail;
    logic signed [48:0] r7_nx, r7_ny, r7_sx, r7_sy;
    logic signed [49:0] r7_px, r7_py;
    logic signed [50:0] r8_ex, r8_ey, r8_fx, r8_fy;

    logic               r_dv [0:ATAN_LAT-1];
    logic               r_df [0:ATAN_LAT-1];
    logic signed [16:0] w_a1, w_a2;

    // result stage, output and skid
    logic signed [17:0] w_u, w_f, w_ua, w_fa;
    logic               r_q_v, r_q_ok;
    logic signed [16:0] r_q_ua, r_q_fa;
    logic               r_out_v, r_out_ok, r_skd_v, r_skd_ok;
    logic signed [16:0] r_out_ua, r_out_fa, r_skd_ua, r_skd_fa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_len  <= '0;
            r_fore_len   <= '0;
            r_upper_zero <= '0;
            r_fore_zero  <= '0;
            r_upper_inv  <= 1'b0;
            r_fore_inv   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UPPER_LENGTH:     r_upper_len  <= i_cfg_data[14:0];
                CFG_FORE_LENGTH:      r_fore_len   <= i_cfg_data[14:0];
                CFG_UPPER_ZERO_ANGLE: r_upper_zero <= $signed(i_cfg_data);
                CFG_FORE_ZERO_ANGLE:  r_fore_zero  <= $signed(i_cfg_data);
                CFG_UPPER_INVERTED:   r_upper_inv  <= i_cfg_data[0];
                CFG_FORE_INVERTED:    r_fore_inv   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance every stage up to the result stage together unless the skid register is full.
    assign w_en        = !r_skd_v;
    assign o_tgt_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_q_v <= 1'b0;
            for (int d = 0; d < ATAN_LAT; d++) begin
                r_dv[d] <= 1'b0;
            end
        end else if (w_en) begin
            r1_v <= i_tgt_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= s_v;
            r8_v <= r7_v;
            r_dv[0] <= r8_v;
            for (int d = 1; d < ATAN_LAT; d++) begin
                r_dv[d] <= r_dv[d-1];
            end
            r_q_v <= r_dv[ATAN_LAT-1];
        end
    end

    // Squares, distance and the reach test
    assign w_nabs = r4_n[32] ? 32'(-r4_n) : 32'(r4_n);
    assign w_gap  = {1'b0, r5_lim} - {1'b0, r5_nsq};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= i_target_x;
            r1_y    <= i_target_y;

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_xx   <= r1_x * r1_x;
            r2_yy   <= r1_y * r1_y;
            r2_r1sq <= r_upper_len * r_upper_len;
            r2_r2sq <= r_fore_len * r_fore_len;

            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_d2   <= $unsigned(r2_xx) + $unsigned(r2_yy);
            r3_dif  <= $signed({1'b0, r2_r1sq}) - $signed({1'b0, r2_r2sq});
            r3_r1sq <= r2_r1sq;

            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_d2   <= r3_d2;
            r4_n    <= 33'(r3_dif) + $signed({1'b0, r3_d2});
            r4_lim  <= {62'(r3_r1sq) * 62'(r3_d2), 2'b00};

            r5_x    <= r4_x;
            r5_y    <= r4_y;
            r5_n    <= r4_n;
            r5_lim  <= r4_lim;
            r5_nsq  <= w_nabs * w_nabs;
            r5_p    <= $signed({1'b0, r4_d2, 1'b0}) - 34'(r4_n);
            r5_d2z  <= (r4_d2 == '0);

            // drop to no solution at the origin or when out of reach
            r6_rad       <= w_gap[62:0];
            r6_side.x    <= r5_x;
            r6_side.y    <= r5_y;
            r6_side.n    <= r5_n;
            r6_side.p    <= r5_p;
            r6_side.fail <= w_gap[64] | r5_d2z;
        end
    end

    tlik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_rad   (r6_rad),
        .i_side  (r6_side),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Pick the upper intersection: the root takes the sign of x.
    assign w_sm = s_side.x[15] ? -$signed({1'b0, s_root}) : $signed({1'b0, s_root});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_fail <= s_side.fail;
            r7_nx   <= s_side.n * s_side.x;
            r7_ny   <= s_side.n * s_side.y;
            r7_px   <= s_side.p * s_side.x;
            r7_py   <= s_side.p * s_side.y;
            r7_sx   <= w_sm * s_side.x;
            r7_sy   <= w_sm * s_side.y;

            r8_fail <= r7_fail;
            r8_ex   <= 51'(r7_nx) - 51'(r7_sy);
            r8_ey   <= 51'(r7_ny) + 51'(r7_sx);
            r8_fx   <= 51'(r7_px) + 51'(r7_sy);
            r8_fy   <= 51'(r7_py) - 51'(r7_sx);

            r_df[0] <= r8_fail;
            for (int d = 1; d < ATAN_LAT; d++) begin
                r_df[d] <= r_df[d-1];
            end
        end
    end

    // base to elbow
    tlik_atan2 u_atan_upper (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r8_ex),
        .i_y   (r8_ey),
        .o_ang (w_a1)
    );

    // elbow to target
    tlik_atan2 u_atan_fore (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r8_fx),
        .i_y   (r8_fy),
        .o_ang (w_a2)
    );

    // Servo angles: offset from the reference pose, negate when inverted.
    assign w_u  = 18'(w_a1) - ANG_RIGHT;
    assign w_f  = 18'(w_a2) - 18'(w_a1);
    assign w_ua = (r_upper_inv ? -w_u : w_u) + 18'(r_upper_zero);
    assign w_fa = (r_fore_inv  ? -w_f : w_f) + 18'(r_fore_zero);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_ok <= !r_df[ATAN_LAT-1];
            r_q_ua <= r_df[ATAN_LAT-1] ? '0 : w_ua[16:0];
            r_q_fa <= r_df[ATAN_LAT-1] ? '0 : w_fa[16:0];
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_out_v && !i_res_ready) begin
            if (r_q_v && w_en) begin
                r_skd_v <= 1'b1;
            end
        end else if (r_skd_v) begin
            r_out_v <= 1'b1;
            r_skd_v <= 1'b0;
        end else begin
            r_out_v <= r_q_v && w_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_res_ready) begin
            if (r_q_v && w_en) begin
                r_skd_ok <= r_q_ok;
                r_skd_ua <= r_q_ua;
                r_skd_fa <= r_q_fa;
            end
        end else if (r_skd_v) begin
            r_out_ok <= r_skd_ok;
            r_out_ua <= r_skd_ua;
            r_out_fa <= r_skd_fa;
        end else if (r_q_v && w_en) begin
            r_out_ok <= r_q_ok;
            r_out_ua <= r_q_ua;
            r_out_fa <= r_q_fa;
        end
    end

    assign o_res_valid   = r_out_v;
    assign o_solved      = r_out_ok;
    assign o_upper_angle = r_out_ua;
    assign o_fore_angle  = r_out_fa;

endmodule

`default_nettype wire
